FILE: sv/fdrd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdrd_pkg
// Shared types, register codes and constants of the face detection row decoder.
// ----------------------------------------------------------------------------
package fdrd_pkg;

   localparam int ROW_ELEMENTS       = 16;
   localparam int ELEM_W             = $clog2(ROW_ELEMENTS);
   localparam int CX_POS             = 0;
   localparam int CY_POS             = 1;
   localparam int W_POS              = 2;
   localparam int H_POS              = 3;
   localparam int LM_POS             = 4;
   localparam int OBJ_POS            = 14;
   localparam int CLS_POS            = 15;
   localparam int LANDMARK_MAX       = 5;
   localparam int LM_SEL_W           = $clog2(LANDMARK_MAX);
   localparam int LANDMARK_COUNT_DEF = 5;
   localparam int ROW_QUEUE_DEPTH    = 2;
   localparam int RESULT_DEPTH       = 4;
   localparam int KIND_W             = 3;
   localparam int CSR_INDEX_W        = 4;
   localparam int CSR_DATA_W         = 32;
   localparam int CONF_W             = 17;
   localparam logic [CONF_W-1:0] CONF_MAX = 17'd65536;

   localparam logic [KIND_W-1:0] POINT_TOP_LEFT     = 3'd0;
   localparam logic [KIND_W-1:0] POINT_BOTTOM_RIGHT = 3'd1;
   localparam logic [KIND_W-1:0] POINT_LANDMARK0    = 3'd2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SCORE_THRESHOLD = 4'd0,
      CSR_MIN_BOX_SIZE    = 4'd1,
      CSR_MAX_BOX_SIZE    = 4'd2,
      CSR_PAD_X           = 4'd3,
      CSR_PAD_Y           = 4'd4,
      CSR_INVERSE_GAIN    = 4'd5,
      CSR_IMAGE_WIDTH     = 4'd6,
      CSR_IMAGE_HEIGHT    = 4'd7
   } csr_index_type;

   typedef struct packed {
      logic [16:0] score_threshold;
      logic [30:0] min_box_size;
      logic [30:0] max_box_size;
      logic [30:0] pad_x;
      logic [30:0] pad_y;
      logic [23:0] inverse_gain;
      logic [13:0] image_width;
      logic [13:0] image_height;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      score_threshold: 17'd16384,
      min_box_size:    31'd131072,
      max_box_size:    31'd268435456,
      pad_x:           31'd0,
      pad_y:           31'd0,
      inverse_gain:    24'd65536,
      image_width:     14'd640,
      image_height:    14'd640
   };

   typedef struct packed {
      logic signed [31:0] value;
      logic               tensor_start;
   } req_type;

   typedef struct packed {
      logic [KIND_W-1:0]  point_kind;
      logic signed [15:0] coord_x;
      logic signed [15:0] coord_y;
      logic [CONF_W-1:0]  confidence;
      logic [15:0]        anchor_index;
      logic               last_point;
   } rsp_type;

   // one passing anchor row as handed from the front to the back
   typedef struct packed {
      logic signed [31:0]                cx;
      logic signed [31:0]                cy;
      logic signed [31:0]                w;
      logic signed [31:0]                h;
      logic [LANDMARK_MAX-1:0][31:0]     lm_x;
      logic [LANDMARK_MAX-1:0][31:0]     lm_y;
      logic [CONF_W-1:0]                 confidence;
      logic [15:0]                       anchor_index;
   } row_type;

endpackage

FILE: sv/fdrd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdrd_fifo
// Small register queue with occupancy count, first word shown at the output.
// ----------------------------------------------------------------------------
module fdrd_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           push_data,
   input  logic                       pop,
   output logic [WIDTH-1:0]           pop_data,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] data_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      r = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
      return r;
   endfunction

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = data_ff[rd_ptr_ff];
   assign count    = count_ff;

endmodule

FILE: sv/fdrd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdrd_front
// Collects tensor elements into a row, scores it and queues passing rows.
// ----------------------------------------------------------------------------
module fdrd_front #(
   parameter int QUEUE_DEPTH = fdrd_pkg::ROW_QUEUE_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_push,
   output logic                             req_full,
   input  fdrd_pkg::req_type                req_data,
   input  fdrd_pkg::cfg_type                cfg,
   input  logic [$clog2(QUEUE_DEPTH+1)-1:0] queue_count,
   output logic                             queue_push,
   output fdrd_pkg::row_type                queue_data
);

   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int EW     = fdrd_pkg::ELEM_W;

   logic signed [31:0] row_ff [fdrd_pkg::OBJ_POS+1];
   logic [EW-1:0]      element_count_ff, element_count_in;
   logic [15:0]        anchor_count_ff, anchor_count_in;
   logic               s1_valid_ff, s1_valid_in;
   fdrd_pkg::row_type  s1_row_ff, s1_row_in;
   logic signed [63:0] prod_ff, prod_in;
   logic               bounds_ok_ff, bounds_ok_in;

   logic               accept;
   logic [EW-1:0]      idx;
   logic [15:0]        anchor;
   logic               row_end;
   logic               credit_ok;
   logic signed [31:0] min_s, max_s;
   logic               score_ok;

   // a row end needs a free queue slot counting the row still being scored
   assign credit_ok = ({1'b0, queue_count} + {{QCNT_W{1'b0}}, s1_valid_ff})
                      < (QCNT_W+1)'(QUEUE_DEPTH);
   assign req_full  = (element_count_ff == EW'(fdrd_pkg::CLS_POS)) && !credit_ok;
   assign accept    = req_push && !req_full;

   always_comb begin
      idx     = req_data.tensor_start ? '0 : element_count_ff;
      anchor  = req_data.tensor_start ? '0 : anchor_count_ff;
      row_end = (idx == EW'(fdrd_pkg::CLS_POS));
      min_s   = $signed({1'b0, cfg.min_box_size});
      max_s   = $signed({1'b0, cfg.max_box_size});

      element_count_in = element_count_ff;
      anchor_count_in  = anchor_count_ff;
      if (accept) begin
         element_count_in = idx + EW'(1);
         anchor_count_in  = row_end ? anchor + 16'd1 : anchor;
      end

      s1_valid_in            = accept && row_end;
      s1_row_in.cx           = row_ff[fdrd_pkg::CX_POS];
      s1_row_in.cy           = row_ff[fdrd_pkg::CY_POS];
      s1_row_in.w            = row_ff[fdrd_pkg::W_POS];
      s1_row_in.h            = row_ff[fdrd_pkg::H_POS];
      for (int k = 0; k < fdrd_pkg::LANDMARK_MAX; k++) begin
         s1_row_in.lm_x[k] = row_ff[fdrd_pkg::LM_POS + 2*k];
         s1_row_in.lm_y[k] = row_ff[fdrd_pkg::LM_POS + 2*k + 1];
      end
      s1_row_in.confidence   = '0;
      s1_row_in.anchor_index = anchor;
      prod_in      = row_ff[fdrd_pkg::OBJ_POS] * req_data.value;
      bounds_ok_in = !(row_ff[fdrd_pkg::W_POS] < min_s || row_ff[fdrd_pkg::H_POS] < min_s ||
                       row_ff[fdrd_pkg::W_POS] > max_s || row_ff[fdrd_pkg::H_POS] > max_s);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         element_count_ff <= '0;
         anchor_count_ff  <= '0;
         s1_valid_ff      <= 1'b0;
      end else begin
         element_count_ff <= element_count_in;
         anchor_count_ff  <= anchor_count_in;
         s1_valid_ff      <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && !row_end) begin
         row_ff[idx] <= req_data.value;
      end
      if (s1_valid_in) begin
         s1_row_ff    <= s1_row_in;
         prod_ff      <= prod_in;
         bounds_ok_ff <= bounds_ok_in;
      end
   end

   // the product is non-negative whenever the threshold test passes
   always_comb begin
      score_ok   = prod_ff >= $signed({31'b0, cfg.score_threshold, 16'b0});
      queue_push = s1_valid_ff && score_ok && bounds_ok_ff;
      queue_data = s1_row_ff;
      queue_data.confidence = (prod_ff[63:16] > 48'(fdrd_pkg::CONF_MAX)) ?
                              fdrd_pkg::CONF_MAX : prod_ff[32:16];
   end

endmodule

FILE: sv/fdrd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdrd_back
// Walks a queued row point by point: pad removal and box corner offset, gain multiply, clip.
// ----------------------------------------------------------------------------
module fdrd_back #(
   parameter int LANDMARK_COUNT = fdrd_pkg::LANDMARK_COUNT_DEF,
   parameter int QUEUE_DEPTH    = fdrd_pkg::ROW_QUEUE_DEPTH,
   parameter int RESULT_DEPTH   = fdrd_pkg::RESULT_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  fdrd_pkg::row_type                 row,
   input  logic [$clog2(QUEUE_DEPTH+1)-1:0]  row_count,
   output logic                              row_pop,
   input  fdrd_pkg::cfg_type                 cfg,
   input  logic [$clog2(RESULT_DEPTH+1)-1:0] result_count,
   output logic                              result_push,
   output fdrd_pkg::rsp_type                 result_data
);

   localparam int POINTS = 2 + LANDMARK_COUNT;
   localparam int KW     = fdrd_pkg::KIND_W;
   localparam int RCNT_W = $clog2(RESULT_DEPTH + 1);
   localparam int SW     = fdrd_pkg::LM_SEL_W;
   localparam logic [KW-1:0] LAST_KIND = KW'(POINTS - 1);

   typedef struct packed {
      logic [KW-1:0]               kind;
      logic                        last;
      logic                        box;
      logic [fdrd_pkg::CONF_W-1:0] conf;
      logic [15:0]                 anchor;
   } meta_type;

   logic [KW-1:0]      point_ff, point_in;
   logic               d_valid_ff, p_valid_ff;
   meta_type           d_meta_ff, d_meta_in, p_meta_ff;
   logic signed [34:0] dx_ff, dx_in, dy_ff, dy_in;
   logic signed [59:0] px_ff, py_ff;

   logic               issue;
   logic               box;
   logic [SW-1:0]      lm_sel;
   logic signed [34:0] pad_x2, pad_y2, w35, h35;
   logic [13:0]        top_x, top_y;

   // truncate toward zero after the 2^33 scale, then clip or saturate
   function automatic logic signed [15:0] finish(input logic signed [59:0] p,
                                                 input logic is_box,
                                                 input logic [13:0] top);
      logic [59:0]        mag;
      logic [26:0]        sh;
      logic signed [15:0] r;
      mag = p[59] ? 60'(-p) : 60'(p);
      sh  = mag[59:33];
      if (is_box) begin
         r = p[59] ? 16'sd0 : ((sh > 27'(top)) ? $signed({2'b0, top}) : $signed(sh[15:0]));
      end else if (p[59]) begin
         r = (sh > 27'd32768) ? -16'sd32768 : $signed(~sh[15:0] + 16'd1);
      end else begin
         r = (sh > 27'd32767) ? 16'sd32767 : $signed(sh[15:0]);
      end
      return r;
   endfunction

   // issue only while every point in flight has a result slot waiting
   assign issue = (row_count != '0) &&
                  (({1'b0, result_count} + (RCNT_W+1)'(d_valid_ff) + (RCNT_W+1)'(p_valid_ff))
                   < (RCNT_W+1)'(RESULT_DEPTH));
   assign row_pop = issue && (point_ff == LAST_KIND);

   always_comb begin
      box    = point_ff < fdrd_pkg::POINT_LANDMARK0;
      lm_sel = box ? '0 : SW'(point_ff - fdrd_pkg::POINT_LANDMARK0);
      pad_x2 = $signed({3'b0, cfg.pad_x, 1'b0});
      pad_y2 = $signed({3'b0, cfg.pad_y, 1'b0});
      w35    = 35'(row.w);
      h35    = 35'(row.h);
      if (box) begin
         dx_in = $signed({{2{row.cx[31]}}, row.cx, 1'b0}) - pad_x2;
         dy_in = $signed({{2{row.cy[31]}}, row.cy, 1'b0}) - pad_y2;
         if (point_ff == fdrd_pkg::POINT_TOP_LEFT) begin
            dx_in = dx_in - w35;
            dy_in = dy_in - h35;
         end else begin
            dx_in = dx_in + w35;
            dy_in = dy_in + h35;
         end
      end else begin
         dx_in = $signed({{2{row.lm_x[lm_sel][31]}}, row.lm_x[lm_sel], 1'b0}) - pad_x2;
         dy_in = $signed({{2{row.lm_y[lm_sel][31]}}, row.lm_y[lm_sel], 1'b0}) - pad_y2;
      end
      d_meta_in.kind   = point_ff;
      d_meta_in.last   = (point_ff == LAST_KIND);
      d_meta_in.box    = box;
      d_meta_in.conf   = row.confidence;
      d_meta_in.anchor = row.anchor_index;
      point_in = issue ? (row_pop ? '0 : point_ff + KW'(1)) : point_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         point_ff   <= '0;
         d_valid_ff <= 1'b0;
         p_valid_ff <= 1'b0;
      end else begin
         point_ff   <= point_in;
         d_valid_ff <= issue;
         p_valid_ff <= d_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
      d_meta_ff <= d_meta_in;
      px_ff     <= dx_ff * $signed({1'b0, cfg.inverse_gain});
      py_ff     <= dy_ff * $signed({1'b0, cfg.inverse_gain});
      p_meta_ff <= d_meta_ff;
   end

   always_comb begin
      top_x = (cfg.image_width == '0) ? '0 : cfg.image_width - 14'd1;
      top_y = (cfg.image_height == '0) ? '0 : cfg.image_height - 14'd1;
      result_push              = p_valid_ff;
      result_data.point_kind   = p_meta_ff.kind;
      result_data.coord_x      = finish(px_ff, p_meta_ff.box, top_x);
      result_data.coord_y      = finish(py_ff, p_meta_ff.box, top_y);
      result_data.confidence   = p_meta_ff.conf;
      result_data.anchor_index = p_meta_ff.anchor;
      result_data.last_point   = p_meta_ff.last;
   end

endmodule

FILE: sv/face_detection_row_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// face_detection_row_decoder_unit
// Decodes face boxes and landmarks from a streamed detector tensor.
// ----------------------------------------------------------------------------
// throughput: one tensor element per cycle unless req_full; a passing row's 7 items leave
// at one per cycle while result slots are free
// pacing: the front stalls only at a row end while the row queue has no free slot
// reset: clears counters, queues and flags, sets register defaults; row data stays unknown
// ----------------------------------------------------------------------------
module face_detection_row_decoder_unit #(
   parameter int LANDMARK_COUNT  = fdrd_pkg::LANDMARK_COUNT_DEF,
   parameter int ROW_QUEUE_DEPTH = fdrd_pkg::ROW_QUEUE_DEPTH,
   parameter int RESULT_DEPTH    = fdrd_pkg::RESULT_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   // tensor element input
   input  logic                                req_push,
   output logic                                req_full,
   input  fdrd_pkg::req_type                   req_data,
   // decoded point output
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output fdrd_pkg::rsp_type                   rsp_data,
   // register writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [fdrd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [fdrd_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int QCNT_W = $clog2(ROW_QUEUE_DEPTH + 1);
   localparam int RCNT_W = $clog2(RESULT_DEPTH + 1);

   fdrd_pkg::cfg_type cfg_ff, cfg_in;
   logic              csr_write;

   logic              queue_push;
   fdrd_pkg::row_type queue_data;
   fdrd_pkg::row_type row_head;
   logic [QCNT_W-1:0] row_count;
   logic              row_pop;

   logic              result_push;
   fdrd_pkg::rsp_type result_data;
   logic [RCNT_W-1:0] result_count;
   logic              result_pop;

   // register file: always ready, each write keeps the low bits of the data
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            fdrd_pkg::CSR_SCORE_THRESHOLD: cfg_in.score_threshold = csr_wdata[16:0];
            fdrd_pkg::CSR_MIN_BOX_SIZE:    cfg_in.min_box_size    = csr_wdata[30:0];
            fdrd_pkg::CSR_MAX_BOX_SIZE:    cfg_in.max_box_size    = csr_wdata[30:0];
            fdrd_pkg::CSR_PAD_X:           cfg_in.pad_x           = csr_wdata[30:0];
            fdrd_pkg::CSR_PAD_Y:           cfg_in.pad_y           = csr_wdata[30:0];
            fdrd_pkg::CSR_INVERSE_GAIN:    cfg_in.inverse_gain    = csr_wdata[23:0];
            fdrd_pkg::CSR_IMAGE_WIDTH:     cfg_in.image_width     = csr_wdata[13:0];
            fdrd_pkg::CSR_IMAGE_HEIGHT:    cfg_in.image_height    = csr_wdata[13:0];
            default:                       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= fdrd_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: row assembly, confidence product and box size test
   fdrd_front #(
      .QUEUE_DEPTH (ROW_QUEUE_DEPTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_data    (req_data),
      .cfg         (cfg_ff),
      .queue_count (row_count),
      .queue_push  (queue_push),
      .queue_data  (queue_data)
   );

   // passing rows wait here so the front keeps streaming while points drain
   fdrd_fifo #(
      .WIDTH ($bits(fdrd_pkg::row_type)),
      .DEPTH (ROW_QUEUE_DEPTH)
   ) u_row_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_data (queue_data),
      .pop       (row_pop),
      .pop_data  (row_head),
      .count     (row_count)
   );

   // back: one point per cycle on result credit via subtract, multiply and clip stages
   fdrd_back #(
      .LANDMARK_COUNT (LANDMARK_COUNT),
      .QUEUE_DEPTH    (ROW_QUEUE_DEPTH),
      .RESULT_DEPTH   (RESULT_DEPTH)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .row          (row_head),
      .row_count    (row_count),
      .row_pop      (row_pop),
      .cfg          (cfg_ff),
      .result_count (result_count),
      .result_push  (result_push),
      .result_data  (result_data)
   );

   // result queue decouples the consumer from the point pipeline
   fdrd_fifo #(
      .WIDTH ($bits(fdrd_pkg::rsp_type)),
      .DEPTH (RESULT_DEPTH)
   ) u_result_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (result_push),
      .push_data (result_data),
      .pop       (result_pop),
      .pop_data  (rsp_data),
      .count     (result_count)
   );

   assign rsp_empty  = (result_count == '0);
   assign result_pop = rsp_pop && !rsp_empty;

   // a row is only taken from a non-empty queue
   a_row_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      row_pop |-> (row_count != '0))
      else $error("row queue popped while empty");

   // the scoring stage never pushes into a full row queue
   a_row_queue_room: assert property (@(posedge clock) disable iff (reset)
      queue_push |-> (row_count < QCNT_W'(ROW_QUEUE_DEPTH)))
      else $error("row queue overflow");

   // result credits keep the result queue from overflowing
   a_result_queue_room: assert property (@(posedge clock) disable iff (reset)
      (result_push && !result_pop) |-> (result_count < RCNT_W'(RESULT_DEPTH)))
      else $error("result queue overflow");

   // every detection closes on its last landmark
   a_last_closes_row: assert property (@(posedge clock) disable iff (reset)
      (result_push && result_data.last_point) |->
         (result_data.point_kind == fdrd_pkg::KIND_W'(LANDMARK_COUNT + 1)))
      else $error("last point carries wrong kind");

endmodule
